FILE: rtl/core/msm_pkg.sv
// Shared types, constants and helpers for the motion stall monitor.
package msm_pkg;

    // Default position width, signed 1/256 inch units
    localparam int POS_BITS_DEF = 20;

    // Fixed field widths
    localparam int TIME_W       = 32;
    localparam int CFG_TIME_W   = 20;
    localparam int DIST_W       = 19;
    localparam int SQ_CFG_W     = 2 * DIST_W;
    localparam int STATUS_W     = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int OUT_FIELDS_W = STATUS_W + TIME_W + 1;
    localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_IDLE    = 3'd0,
        ST_RUN     = 3'd1,
        ST_DONE    = 3'd2,
        ST_TIMEOUT = 3'd3,
        ST_STALL   = 3'd4
    } status_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT   = 3'd0,
        CFG_STALL_WIN = 3'd1,
        CFG_MOVE_EPS  = 3'd2,
        CFG_TARGET_X  = 3'd3,
        CFG_TARGET_Y  = 3'd4,
        CFG_NEAR_RAD  = 3'd5,
        CFG_NEAR_EN   = 3'd6
    } cfg_idx_t;

    // Register reset values (epsilon and radius are held squared)
    localparam logic [CFG_TIME_W-1:0] TIMEOUT_RST   = 20'd5000;
    localparam logic [CFG_TIME_W-1:0] STALL_WIN_RST = 20'd300;
    localparam logic [SQ_CFG_W-1:0]   EPS_SQ_RST    = 38'd16384;
    localparam logic [SQ_CFG_W-1:0]   RAD_SQ_RST    = 38'd274876858369;

    // Square of a distance threshold, taken once at register write
    function automatic logic [SQ_CFG_W-1:0] cfg_square(input logic [DIST_W-1:0] v);
        logic [SQ_CFG_W-1:0] r;
        r = SQ_CFG_W'(v) * SQ_CFG_W'(v);
        return r;
    endfunction

endpackage

FILE: rtl/core/msm_sqdist.sv
// Per-axis squared difference of two signed positions.
module msm_sqdist #(
    parameter int POS_BITS = msm_pkg::POS_BITS_DEF,
    localparam int SQ_W = 2 * POS_BITS
) (
    input  logic signed [POS_BITS-1:0] ax,
    input  logic signed [POS_BITS-1:0] ay,
    input  logic signed [POS_BITS-1:0] bx,
    input  logic signed [POS_BITS-1:0] by,
    output logic [SQ_W-1:0]            sq_x,
    output logic [SQ_W-1:0]            sq_y
);

    logic signed [POS_BITS:0] dx;
    logic signed [POS_BITS:0] dy;
    logic [POS_BITS-1:0]      mag_x;
    logic [POS_BITS-1:0]      mag_y;

    // Difference needs one extra bit; its magnitude fits back in POS_BITS
    always_comb
    begin
        dx    = {ax[POS_BITS-1], ax} - {bx[POS_BITS-1], bx};
        dy    = {ay[POS_BITS-1], ay} - {by[POS_BITS-1], by};
        mag_x = dx[POS_BITS] ? POS_BITS'(-dx) : dx[POS_BITS-1:0];
        mag_y = dy[POS_BITS] ? POS_BITS'(-dy) : dy[POS_BITS-1:0];
    end

    // Exact squares, no saturation needed at these widths
    assign sq_x = SQ_W'(mag_x) * SQ_W'(mag_x);
    assign sq_y = SQ_W'(mag_y) * SQ_W'(mag_y);

endmodule

FILE: rtl/core/motion_stall_monitor_top.sv
// Motion stall monitor: pose sample in, one status word out per sample.
//
//  Channel | Dir | Handshake          | Content
//  --------+-----+--------------------+--------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | pose sample: tuser start_req, tdata fields
//  m_*     | out | m_tvalid/m_tready  | status, elapsed_ms, has_moved_flag
//  cfg_*   | in  | cfg_valid/cfg_ready| register index and write data
//
// One sample per cycle sustained while m_tready holds; m_tvalid rises after the input
// register, squaring stage register, then decision into the result register.
// The squaring stage computes the distance against both the stored reference
// and the pose of the word ahead, so back-to-back samples need no stall.
// Reset clears all control and state; config registers take their defaults.
// A stalled output fills the empty stages behind it before s_tready drops.
module motion_stall_monitor_top #(
    parameter int POS_BITS = msm_pkg::POS_BITS_DEF,
    localparam int IN_W  = ((2 * POS_BITS + msm_pkg::TIME_W + 1 + 7) / 8) * 8,
    localparam int CFG_W = (POS_BITS > msm_pkg::CFG_TIME_W) ? POS_BITS : msm_pkg::CFG_TIME_W
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // tdata: in_motion, now_ms[31:0], pose_x, pose_y, zero pad
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [IN_W-1:0]               s_tdata,
    // tuser: start_req
    input  logic                          s_tuser,
    // tdata: status[2:0], elapsed_ms[31:0], has_moved_flag, zero pad
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [msm_pkg::OUT_W-1:0]     m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [msm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]              cfg_data
);

    import msm_pkg::*;

    localparam int SQ_W  = 2 * POS_BITS;
    localparam int SUM_W = SQ_W + 1;
    localparam int CMP_W = (SUM_W > SQ_CFG_W) ? SUM_W : SQ_CFG_W;
    localparam int PAD_W = OUT_W - OUT_FIELDS_W;

    // Configuration registers
    logic [CFG_TIME_W-1:0]      timeout_reg;
    logic [CFG_TIME_W-1:0]      stall_win_reg;
    logic [SQ_CFG_W-1:0]        eps_sq_reg;
    logic signed [POS_BITS-1:0] target_x_reg;
    logic signed [POS_BITS-1:0] target_y_reg;
    logic [SQ_CFG_W-1:0]        rad_sq_reg;
    logic                       near_en_reg;

    // Pipeline enables
    logic en_out;
    logic en_s1;
    logic en_s0;
    logic s1_fire;

    // Input stage
    logic                       s0_valid_reg;
    logic                       s0_start_reg;
    logic                       s0_motion_reg;
    logic [TIME_W-1:0]          s0_now_reg;
    logic signed [POS_BITS-1:0] s0_px_reg;
    logic signed [POS_BITS-1:0] s0_py_reg;

    // Squares from the input stage
    logic [SQ_W-1:0] ref_sqx;
    logic [SQ_W-1:0] ref_sqy;
    logic [SQ_W-1:0] fwd_sqx;
    logic [SQ_W-1:0] fwd_sqy;
    logic [SQ_W-1:0] tgt_sqx;
    logic [SQ_W-1:0] tgt_sqy;

    // Decision stage
    logic                       s1_valid_reg;
    logic                       s1_use_fwd_reg;
    logic                       s1_start_reg;
    logic                       s1_motion_reg;
    logic [TIME_W-1:0]          s1_now_reg;
    logic signed [POS_BITS-1:0] s1_px_reg;
    logic signed [POS_BITS-1:0] s1_py_reg;
    logic [SQ_W-1:0]            s1_ref_sqx_reg;
    logic [SQ_W-1:0]            s1_ref_sqy_reg;
    logic [SQ_W-1:0]            s1_fwd_sqx_reg;
    logic [SQ_W-1:0]            s1_fwd_sqy_reg;
    logic [SQ_W-1:0]            s1_tgt_sqx_reg;
    logic [SQ_W-1:0]            s1_tgt_sqy_reg;

    // Monitor state
    logic                       active_reg;
    logic                       active_next;
    logic [TIME_W-1:0]          start_time_reg;
    logic [TIME_W-1:0]          start_time_next;
    logic [TIME_W-1:0]          last_move_reg;
    logic [TIME_W-1:0]          last_move_next;
    logic signed [POS_BITS-1:0] ref_x_reg;
    logic signed [POS_BITS-1:0] ref_x_next;
    logic signed [POS_BITS-1:0] ref_y_reg;
    logic signed [POS_BITS-1:0] ref_y_next;
    logic                       moved_reg;
    logic                       moved_next;
    logic                       ref_upd;

    // Decision terms
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] quiet;
    logic [SQ_W-1:0]   sel_sqx;
    logic [SQ_W-1:0]   sel_sqy;
    logic [CMP_W-1:0]  dist_sq;
    logic [CMP_W-1:0]  tgt_sq;
    logic              far_enough;
    logic              near_ok;

    // Result register
    logic              out_valid_reg;
    status_t           out_status_reg;
    status_t           out_status_next;
    logic [TIME_W-1:0] out_elapsed_reg;
    logic [TIME_W-1:0] out_elapsed_next;
    logic              out_moved_reg;
    logic              out_moved_next;

    // Configuration writes, always accepted
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= TIMEOUT_RST;
            stall_win_reg <= STALL_WIN_RST;
            eps_sq_reg    <= EPS_SQ_RST;
            target_x_reg  <= '0;
            target_y_reg  <= '0;
            rad_sq_reg    <= RAD_SQ_RST;
            near_en_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_TIMEOUT:   timeout_reg   <= cfg_data[CFG_TIME_W-1:0];
                CFG_STALL_WIN: stall_win_reg <= cfg_data[CFG_TIME_W-1:0];
                CFG_MOVE_EPS:  eps_sq_reg    <= cfg_square(cfg_data[DIST_W-1:0]);
                CFG_TARGET_X:  target_x_reg  <= cfg_data[POS_BITS-1:0];
                CFG_TARGET_Y:  target_y_reg  <= cfg_data[POS_BITS-1:0];
                CFG_NEAR_RAD:  rad_sq_reg    <= cfg_square(cfg_data[DIST_W-1:0]);
                CFG_NEAR_EN:   near_en_reg   <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // Stage enables: each stage moves when the one after it has room
    assign en_out   = !out_valid_reg || m_tready;
    assign en_s1    = !s1_valid_reg || en_out;
    assign en_s0    = !s0_valid_reg || en_s1;
    assign s1_fire  = s1_valid_reg && en_out;
    assign s_tready = en_s0;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (en_s0)
            s0_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en_s0 && s_tvalid)
        begin
            s0_start_reg  <= s_tuser;
            s0_motion_reg <= s_tdata[0];
            s0_now_reg    <= s_tdata[TIME_W:1];
            s0_px_reg     <= s_tdata[TIME_W+1 +: POS_BITS];
            s0_py_reg     <= s_tdata[TIME_W+1+POS_BITS +: POS_BITS];
        end
    end

    // Squares against the stored reference, the pose ahead, and the target
    msm_sqdist #(.POS_BITS(POS_BITS)) u_sq_ref (
        .ax   (s0_px_reg),
        .ay   (s0_py_reg),
        .bx   (ref_x_reg),
        .by   (ref_y_reg),
        .sq_x (ref_sqx),
        .sq_y (ref_sqy)
    );

    msm_sqdist #(.POS_BITS(POS_BITS)) u_sq_fwd (
        .ax   (s0_px_reg),
        .ay   (s0_py_reg),
        .bx   (s1_px_reg),
        .by   (s1_py_reg),
        .sq_x (fwd_sqx),
        .sq_y (fwd_sqy)
    );

    msm_sqdist #(.POS_BITS(POS_BITS)) u_sq_tgt (
        .ax   (target_x_reg),
        .ay   (target_y_reg),
        .bx   (s0_px_reg),
        .by   (s0_py_reg),
        .sq_x (tgt_sqx),
        .sq_y (tgt_sqy)
    );

    // Decision stage register; forward flag marks a reference renewed by the word ahead
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s1_use_fwd_reg <= 1'b0;
        end
        else if (en_s1)
        begin
            s1_valid_reg   <= s0_valid_reg;
            s1_use_fwd_reg <= s1_fire && ref_upd && s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_s1 && s0_valid_reg)
        begin
            s1_start_reg   <= s0_start_reg;
            s1_motion_reg  <= s0_motion_reg;
            s1_now_reg     <= s0_now_reg;
            s1_px_reg      <= s0_px_reg;
            s1_py_reg      <= s0_py_reg;
            s1_ref_sqx_reg <= ref_sqx;
            s1_ref_sqy_reg <= ref_sqy;
            s1_fwd_sqx_reg <= fwd_sqx;
            s1_fwd_sqy_reg <= fwd_sqy;
            s1_tgt_sqx_reg <= tgt_sqx;
            s1_tgt_sqy_reg <= tgt_sqy;
        end
    end

    // Distance sums and threshold compares
    always_comb
    begin
        sel_sqx    = s1_use_fwd_reg ? s1_fwd_sqx_reg : s1_ref_sqx_reg;
        sel_sqy    = s1_use_fwd_reg ? s1_fwd_sqy_reg : s1_ref_sqy_reg;
        dist_sq    = CMP_W'(sel_sqx) + CMP_W'(sel_sqy);
        tgt_sq     = CMP_W'(s1_tgt_sqx_reg) + CMP_W'(s1_tgt_sqy_reg);
        far_enough = dist_sq >= CMP_W'(eps_sq_reg);
        near_ok    = !near_en_reg || (tgt_sq <= CMP_W'(rad_sq_reg));
        elapsed    = s1_now_reg - start_time_reg;
    end

    // Next state and result for the word in the decision stage
    always_comb
    begin
        active_next      = active_reg;
        start_time_next  = start_time_reg;
        last_move_next   = last_move_reg;
        ref_x_next       = ref_x_reg;
        ref_y_next       = ref_y_reg;
        moved_next       = moved_reg;
        ref_upd          = 1'b0;
        out_status_next  = ST_IDLE;
        out_elapsed_next = '0;
        out_moved_next   = 1'b0;
        quiet            = '0;
        if (s1_start_reg)
        begin
            // new wait: this sample becomes the reference
            active_next     = 1'b1;
            start_time_next = s1_now_reg;
            last_move_next  = s1_now_reg;
            ref_x_next      = s1_px_reg;
            ref_y_next      = s1_py_reg;
            moved_next      = 1'b0;
            ref_upd         = 1'b1;
            out_status_next = ST_RUN;
        end
        else if (active_reg)
        begin
            out_elapsed_next = elapsed;
            if (!s1_motion_reg)
            begin
                out_status_next = ST_DONE;
                active_next     = 1'b0;
            end
            else if (elapsed >= TIME_W'(timeout_reg))
            begin
                out_status_next = ST_TIMEOUT;
                active_next     = 1'b0;
            end
            else
            begin
                out_status_next = ST_RUN;
                if (far_enough)
                begin
                    moved_next     = 1'b1;
                    ref_x_next     = s1_px_reg;
                    ref_y_next     = s1_py_reg;
                    last_move_next = s1_now_reg;
                    ref_upd        = 1'b1;
                end
                quiet = s1_now_reg - last_move_next;
                if (moved_next && (quiet >= TIME_W'(stall_win_reg)) && near_ok)
                begin
                    out_status_next = ST_STALL;
                    active_next     = 1'b0;
                end
            end
            out_moved_next = moved_next;
        end
    end

    // State update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            start_time_reg <= '0;
            last_move_reg  <= '0;
            ref_x_reg      <= '0;
            ref_y_reg      <= '0;
            moved_reg      <= 1'b0;
        end
        else if (s1_fire)
        begin
            active_reg     <= active_next;
            start_time_reg <= start_time_next;
            last_move_reg  <= last_move_next;
            ref_x_reg      <= ref_x_next;
            ref_y_reg      <= ref_y_next;
            moved_reg      <= moved_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en_out)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_status_reg  <= out_status_next;
            out_elapsed_reg <= out_elapsed_next;
            out_moved_reg   <= out_moved_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_moved_reg, out_elapsed_reg, out_status_reg};

    // A start word always reports running with nothing moved yet
    a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_start_reg |=>
            out_status_reg == ST_RUN && !out_moved_reg && out_elapsed_reg == '0)
        else $error("start word gave wrong result");

    // Idle words report idle
    a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && !s1_start_reg && !active_reg |=> out_status_reg == ST_IDLE)
        else $error("idle word gave non-idle status");

    // Any ending status closes the wait
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && (out_status_next == ST_DONE || out_status_next == ST_TIMEOUT ||
                    out_status_next == ST_STALL) |=> !active_reg)
        else $error("wait still active after ending status");

    // A stall can only follow movement
    a_stall_moved: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg == ST_STALL |-> out_moved_reg)
        else $error("stall reported without movement");

    // Forwarded squares only stand against a word that is really there
    a_fwd_valid: assert property (@(posedge clk) disable iff (!rst_n)
        s1_use_fwd_reg |-> s1_valid_reg)
        else $error("forward select set on empty stage");

endmodule
